// File: hw/rtl/incpid_pkg.sv
// shared types, constants and saturating helpers for the incremental pid unit
`default_nettype none

package incpid_pkg;

  localparam int DATA_W         = 32;
  localparam int FRAC_BITS      = 16;
  localparam int TIME_FRAC_BITS = 24;
  localparam int DT_W           = 24;
  localparam int CFG_IDX_W      = 3;
  localparam int DEADBAND_W     = 31;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [DT_W-1:0]          dt_t;

  localparam data_t DATA_MAX = data_t'({1'b0, {(DATA_W-1){1'b1}}});
  localparam data_t DATA_MIN = data_t'({1'b1, {(DATA_W-1){1'b0}}});

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_PRESET = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P   = 3'd0,
    CFG_GAIN_I   = 3'd1,
    CFG_GAIN_D   = 3'd2,
    CFG_OUT_LOW  = 3'd3,
    CFG_OUT_HIGH = 3'd4,
    CFG_DEADBAND = 3'd5
  } cfg_index_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PRESET,
    ST_ERR,
    ST_DBAND,
    ST_FF,
    ST_CMIN,
    ST_CMAX,
    ST_WIN,
    ST_DIFF,
    ST_DBL,
    ST_MUL_P,
    ST_MUL_GI,
    ST_MUL_D,
    ST_MUL_I,
    ST_DIV,
    ST_ADD_I,
    ST_DIV_WAIT,
    ST_CLAMP_ACC,
    ST_OUT_SUM,
    ST_OUT_CLAMP,
    ST_FINISH
  } state_t;

  // a + b or a - b, saturated to the data range
  function automatic data_t sat_add(input data_t a, input data_t b, input logic sub);
    logic [DATA_W:0] ax;
    logic [DATA_W:0] bx;
    logic [DATA_W:0] s;
    ax = {a[DATA_W-1], a};
    bx = {b[DATA_W-1], b};
    s  = sub ? (ax - bx) : (ax + bx);
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? DATA_MIN : DATA_MAX;
    end
    return data_t'(s[DATA_W-1:0]);
  endfunction

  // lower bound first, upper bound last
  function automatic data_t clamp(input data_t x, input data_t lo, input data_t hi);
    data_t r;
    r = x;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/incpid_mulq.sv
// shared two-stage fixed-point multiplier with shift, truncation toward zero and saturation
`default_nettype none

module incpid_mulq (
  input  wire logic              clk,
  input  wire incpid_pkg::data_t a,
  input  wire incpid_pkg::data_t b,
  input  wire logic              time_scale,
  output incpid_pkg::data_t      res
);

  localparam int DW     = incpid_pkg::DATA_W;
  localparam int PROD_W = 2 * DW;

  logic [DW-1:0]     mag_a;
  logic [DW-1:0]     mag_b;
  logic [PROD_W-1:0] prod;
  logic              neg;
  logic              tsel;
  logic [PROD_W-1:0] shifted;
  logic              big;
  incpid_pkg::data_t res_next;

  assign mag_a = a[DW-1] ? DW'(-a) : DW'(a);
  assign mag_b = b[DW-1] ? DW'(-b) : DW'(b);

  // stage 1: magnitude product
  always_ff @(posedge clk) begin
    prod <= PROD_W'(mag_a) * PROD_W'(mag_b);
    neg  <= a[DW-1] ^ b[DW-1];
    tsel <= time_scale;
  end

  // stage 2: scale and saturate
  always_comb begin
    shifted = tsel ? (prod >> incpid_pkg::TIME_FRAC_BITS) : (prod >> incpid_pkg::FRAC_BITS);
    big     = |shifted[PROD_W-1:DW-1];
    if (big) begin
      res_next = neg ? incpid_pkg::DATA_MIN : incpid_pkg::DATA_MAX;
    end else if (neg) begin
      res_next = -incpid_pkg::data_t'(shifted[DW-1:0]);
    end else begin
      res_next = incpid_pkg::data_t'(shifted[DW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

`default_nettype wire

// File: hw/rtl/incpid_divq.sv
// iterative restoring divider, two quotient bits per cycle, for the derivative term
`default_nettype none

module incpid_divq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire incpid_pkg::data_t dividend,
  input  wire incpid_pkg::dt_t   divisor,
  output logic                   done,
  output incpid_pkg::data_t      quotient
);

  localparam int DW        = incpid_pkg::DATA_W;
  localparam int DTW       = incpid_pkg::DT_W;
  localparam int TFB       = incpid_pkg::TIME_FRAC_BITS;
  localparam int CYCLES    = DW / 2;
  localparam int CNT_W     = $clog2(CYCLES);
  localparam int REM_SHIFT = DW - TFB;
  localparam int OVF_PAD   = DW - 1 - TFB;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DTW-1:0]   rem;
  logic [DW-1:0]    num;
  logic [DW-1:0]    quo;
  logic             neg;
  logic             ovf;

  logic [DW-1:0]    mag;
  logic             ovf_in;
  logic [DTW:0]     r1;
  logic [DTW:0]     r1s;
  logic [DTW:0]     r2;
  logic [DTW:0]     r2s;
  logic             b1;
  logic             b2;

  assign mag    = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
  // quotient of mag << TFB reaches the sign bit exactly when mag >= divisor << OVF_PAD
  assign ovf_in = mag >= DW'({1'b0, divisor, {OVF_PAD{1'b0}}});

  always_comb begin
    r1  = {rem, num[DW-1]};
    b1  = r1 >= {1'b0, divisor};
    r1s = b1 ? (r1 - {1'b0, divisor}) : r1;
    r2  = {r1s[DTW-1:0], num[DW-2]};
    b2  = r2 >= {1'b0, divisor};
    r2s = b2 ? (r2 - {1'b0, divisor}) : r2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= !ovf_in;
      done <= ovf_in;
      cnt  <= CNT_W'(CYCLES - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DW-1];
      ovf <= ovf_in;
      rem <= DTW'(mag >> REM_SHIFT);
      num <= DW'(mag << TFB);
      quo <= '0;
    end else if (busy) begin
      rem <= r2s[DTW-1:0];
      num <= num << 2;
      quo <= {quo[DW-3:0], b1, b2};
    end
  end

  always_comb begin
    if (ovf) begin
      quotient = neg ? incpid_pkg::DATA_MIN : incpid_pkg::DATA_MAX;
    end else if (neg) begin
      quotient = -incpid_pkg::data_t'(quo);
    end else begin
      quotient = incpid_pkg::data_t'(quo);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/incremental_pid_with_feedforward_unit.sv
// top level of the velocity-form pid speed controller with feedforward
//
//  channel   signals                                   direction  transfer when
//  config    cfg_write, cfg_index, cfg_data            in         cfg_write high
//  update    in_valid/in_ready, op, target_speed ...   in         in_valid & in_ready
//  result    out_valid/out_ready, drive_output, ...    out        out_valid & out_ready
//
// an update item runs through the sequencer states in order: error, deadband, feedforward,
//   correction window, error differences, the p, i-gain, d and i products, the derivative
//   divide (two quotient bits per cycle) and the accumulator and output clamps; the divider
//   and the two-stage shared multiplier pipeline set its length, the rest is saturating adds and clamps
// when the derivative quotient saturates the divider finishes at once, without iterating
// a preset item runs only the preset and finish states, a zero time step only the finish state
// rst is synchronous; it restores register defaults and clears the controller history
// a finished result sits in the output register while the next item is taken in;
//   the sequencer stalls in its last state only while that register is still full
`default_nettype none

module incremental_pid_with_feedforward_unit (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_write,
  input  wire logic [incpid_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [incpid_pkg::DATA_W-1:0]          cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   op,
  input  wire incpid_pkg::data_t                      target_speed,
  input  wire incpid_pkg::data_t                      measured_speed,
  input  wire incpid_pkg::dt_t                        step_time,
  input  wire incpid_pkg::data_t                      feedforward_value,
  input  wire incpid_pkg::data_t                      correction_limit,
  input  wire incpid_pkg::data_t                      preset_output,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output incpid_pkg::data_t                           drive_output,
  output logic                                        step_skipped
);

  localparam int DW  = incpid_pkg::DATA_W;
  localparam int DTW = incpid_pkg::DT_W;

  // configuration registers
  incpid_pkg::data_t gain_p;
  incpid_pkg::data_t gain_i;
  incpid_pkg::data_t gain_d;
  incpid_pkg::data_t out_low_limit;
  incpid_pkg::data_t out_high_limit;
  logic [incpid_pkg::DEADBAND_W-1:0] error_deadband;

  // controller history
  incpid_pkg::data_t last_output;
  incpid_pkg::data_t feedback_accum;
  incpid_pkg::data_t prev_error;
  incpid_pkg::data_t prev_prev_error;
  logic              seeded;

  // sequencer
  incpid_pkg::state_t state;
  incpid_pkg::state_t state_next;

  // latched item and working registers
  logic              op_q;
  incpid_pkg::data_t tgt;
  incpid_pkg::data_t meas;
  incpid_pkg::dt_t   dt;
  incpid_pkg::data_t ff_in;
  incpid_pkg::data_t lim_in;
  incpid_pkg::data_t preset;
  incpid_pkg::data_t err;
  incpid_pkg::data_t ff;
  incpid_pkg::data_t lim;
  incpid_pkg::data_t cmin;
  incpid_pkg::data_t cmax;
  incpid_pkg::data_t tmp_a;
  incpid_pkg::data_t tmp_b;
  incpid_pkg::data_t acc;
  incpid_pkg::data_t res_data;
  logic              res_skip;

  // shared units
  incpid_pkg::data_t alu_a;
  incpid_pkg::data_t alu_b;
  logic              alu_sub;
  incpid_pkg::data_t alu_res;
  incpid_pkg::data_t clamp_x;
  incpid_pkg::data_t clamp_lo;
  incpid_pkg::data_t clamp_hi;
  incpid_pkg::data_t clamp_res;
  incpid_pkg::data_t mul_a;
  incpid_pkg::data_t mul_b;
  logic              mul_tsel;
  incpid_pkg::data_t mul_res;
  logic              div_start;
  logic              div_done;
  incpid_pkg::data_t div_res;

  logic              in_fire;
  logic              out_free;
  logic [DW-1:0]     err_mag;
  incpid_pkg::data_t err_db;
  incpid_pkg::data_t neg_lim;

  // config write side: post-write limits for the implied preset of zero
  logic              cfg_hit;
  incpid_pkg::data_t cfg_lo;
  incpid_pkg::data_t cfg_hi;
  incpid_pkg::data_t cfg_preset;

  assign in_ready = (state == incpid_pkg::ST_IDLE) && !cfg_write;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // deadband on the fresh error
  assign err_mag = err[DW-1] ? DW'(-err) : DW'(err);
  assign err_db  = (err_mag < {1'b0, error_deadband}) ? '0 : err;
  assign neg_lim = -lim;

  always_comb begin
    cfg_hit = 1'b1;
    cfg_lo  = out_low_limit;
    cfg_hi  = out_high_limit;
    case (cfg_index)
      incpid_pkg::CFG_GAIN_P,
      incpid_pkg::CFG_GAIN_I,
      incpid_pkg::CFG_GAIN_D,
      incpid_pkg::CFG_DEADBAND: begin
      end
      incpid_pkg::CFG_OUT_LOW: begin
        cfg_lo = incpid_pkg::data_t'(cfg_data);
      end
      incpid_pkg::CFG_OUT_HIGH: begin
        cfg_hi = incpid_pkg::data_t'(cfg_data);
      end
      default: begin
        cfg_hit = 1'b0;
      end
    endcase
    cfg_preset = incpid_pkg::clamp('0, cfg_lo, cfg_hi);
  end

  assign alu_res   = incpid_pkg::sat_add(alu_a, alu_b, alu_sub);
  assign clamp_res = incpid_pkg::clamp(clamp_x, clamp_lo, clamp_hi);

  incpid_mulq u_mulq (
    .clk        (clk),
    .a          (mul_a),
    .b          (mul_b),
    .time_scale (mul_tsel),
    .res        (mul_res)
  );

  incpid_divq u_divq (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_res),
    .divisor  (dt),
    .done     (div_done),
    .quotient (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= incpid_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and operand routing for the shared units
  always_comb begin
    state_next = state;
    alu_a      = '0;
    alu_b      = '0;
    alu_sub    = 1'b0;
    clamp_x    = acc;
    clamp_lo   = out_low_limit;
    clamp_hi   = out_high_limit;
    mul_a      = gain_p;
    mul_b      = tmp_a;
    mul_tsel   = 1'b0;
    div_start  = 1'b0;
    case (state)
      incpid_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (op == incpid_pkg::OP_PRESET) begin
            state_next = incpid_pkg::ST_PRESET;
          end else if (step_time == '0) begin
            state_next = incpid_pkg::ST_FINISH;
          end else begin
            state_next = incpid_pkg::ST_ERR;
          end
        end
      end
      incpid_pkg::ST_PRESET: begin
        clamp_x    = preset;
        state_next = incpid_pkg::ST_FINISH;
      end
      incpid_pkg::ST_ERR: begin
        alu_a      = tgt;
        alu_b      = meas;
        alu_sub    = 1'b1;
        state_next = incpid_pkg::ST_DBAND;
      end
      incpid_pkg::ST_DBAND: begin
        state_next = incpid_pkg::ST_FF;
      end
      incpid_pkg::ST_FF: begin
        clamp_x    = ff_in;
        state_next = incpid_pkg::ST_CMIN;
      end
      incpid_pkg::ST_CMIN: begin
        alu_a      = out_low_limit;
        alu_b      = ff;
        alu_sub    = 1'b1;
        state_next = incpid_pkg::ST_CMAX;
      end
      incpid_pkg::ST_CMAX: begin
        alu_a      = out_high_limit;
        alu_b      = ff;
        alu_sub    = 1'b1;
        state_next = incpid_pkg::ST_WIN;
      end
      incpid_pkg::ST_WIN: begin
        state_next = incpid_pkg::ST_DIFF;
      end
      incpid_pkg::ST_DIFF: begin
        // first difference for the p term
        alu_a      = err;
        alu_b      = prev_error;
        alu_sub    = 1'b1;
        state_next = incpid_pkg::ST_DBL;
      end
      incpid_pkg::ST_DBL: begin
        alu_a      = prev_error;
        alu_b      = prev_error;
        state_next = incpid_pkg::ST_MUL_P;
      end
      incpid_pkg::ST_MUL_P: begin
        mul_a      = gain_p;
        mul_b      = tmp_a;
        alu_a      = err;
        alu_b      = tmp_b;
        alu_sub    = 1'b1;
        state_next = incpid_pkg::ST_MUL_GI;
      end
      incpid_pkg::ST_MUL_GI: begin
        // integral gain scaled by the time step
        mul_a      = gain_i;
        mul_b      = incpid_pkg::data_t'({{(DW-DTW){1'b0}}, dt});
        mul_tsel   = 1'b1;
        alu_a      = tmp_b;
        alu_b      = prev_prev_error;
        state_next = incpid_pkg::ST_MUL_D;
      end
      incpid_pkg::ST_MUL_D: begin
        // p product arrives here
        mul_a      = gain_d;
        mul_b      = tmp_b;
        alu_a      = feedback_accum;
        alu_b      = mul_res;
        state_next = incpid_pkg::ST_MUL_I;
      end
      incpid_pkg::ST_MUL_I: begin
        // scaled integral gain arrives here and goes straight back in
        mul_a      = mul_res;
        mul_b      = err;
        state_next = incpid_pkg::ST_DIV;
      end
      incpid_pkg::ST_DIV: begin
        // d product arrives here and feeds the divider
        div_start  = 1'b1;
        state_next = incpid_pkg::ST_ADD_I;
      end
      incpid_pkg::ST_ADD_I: begin
        alu_a      = acc;
        alu_b      = mul_res;
        state_next = incpid_pkg::ST_DIV_WAIT;
      end
      incpid_pkg::ST_DIV_WAIT: begin
        alu_a = acc;
        alu_b = div_res;
        if (div_done) begin
          state_next = incpid_pkg::ST_CLAMP_ACC;
        end
      end
      incpid_pkg::ST_CLAMP_ACC: begin
        clamp_x    = acc;
        clamp_lo   = cmin;
        clamp_hi   = cmax;
        state_next = incpid_pkg::ST_OUT_SUM;
      end
      incpid_pkg::ST_OUT_SUM: begin
        alu_a      = ff;
        alu_b      = feedback_accum;
        state_next = incpid_pkg::ST_OUT_CLAMP;
      end
      incpid_pkg::ST_OUT_CLAMP: begin
        clamp_x    = acc;
        state_next = incpid_pkg::ST_FINISH;
      end
      incpid_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = incpid_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = incpid_pkg::ST_IDLE;
      end
    endcase
  end

  // configuration, controller history and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p          <= '0;
      gain_i          <= '0;
      gain_d          <= '0;
      out_low_limit   <= incpid_pkg::DATA_MIN;
      out_high_limit  <= incpid_pkg::DATA_MAX;
      error_deadband  <= '0;
      last_output     <= '0;
      feedback_accum  <= '0;
      prev_error      <= '0;
      prev_prev_error <= '0;
      seeded          <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write && cfg_hit) begin
        case (cfg_index)
          incpid_pkg::CFG_GAIN_P:   gain_p         <= incpid_pkg::data_t'(cfg_data);
          incpid_pkg::CFG_GAIN_I:   gain_i         <= incpid_pkg::data_t'(cfg_data);
          incpid_pkg::CFG_GAIN_D:   gain_d         <= incpid_pkg::data_t'(cfg_data);
          incpid_pkg::CFG_OUT_LOW:  out_low_limit  <= incpid_pkg::data_t'(cfg_data);
          incpid_pkg::CFG_OUT_HIGH: out_high_limit <= incpid_pkg::data_t'(cfg_data);
          incpid_pkg::CFG_DEADBAND: error_deadband <= cfg_data[incpid_pkg::DEADBAND_W-1:0];
          default: begin
          end
        endcase
        // every accepted register write also presets the output to zero, clamped into the post-write limits
        last_output     <= cfg_preset;
        feedback_accum  <= cfg_preset;
        prev_error      <= '0;
        prev_prev_error <= '0;
        seeded          <= 1'b0;
      end
      case (state)
        incpid_pkg::ST_PRESET: begin
          last_output     <= clamp_res;
          feedback_accum  <= clamp_res;
          prev_error      <= '0;
          prev_prev_error <= '0;
          seeded          <= 1'b0;
        end
        incpid_pkg::ST_DBAND: begin
          // first update after a preset, a register write or reset seeds both history taps
          if (!seeded) begin
            prev_error      <= err_db;
            prev_prev_error <= err_db;
            seeded          <= 1'b1;
          end
        end
        incpid_pkg::ST_CLAMP_ACC: begin
          feedback_accum <= clamp_res;
        end
        incpid_pkg::ST_OUT_CLAMP: begin
          last_output     <= clamp_res;
          prev_prev_error <= prev_error;
          prev_error      <= err;
        end
        default: begin
        end
      endcase
      if (state == incpid_pkg::ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      incpid_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_q     <= op;
          tgt      <= target_speed;
          meas     <= measured_speed;
          dt       <= step_time;
          ff_in    <= feedforward_value;
          lim_in   <= correction_limit;
          preset   <= preset_output;
          // zero time step holds the output
          res_data <= last_output;
          res_skip <= (op == incpid_pkg::OP_UPDATE) && (step_time == '0);
        end
      end
      incpid_pkg::ST_PRESET: begin
        res_data <= clamp_res;
      end
      incpid_pkg::ST_ERR: begin
        err <= alu_res;
      end
      incpid_pkg::ST_DBAND: begin
        err <= err_db;
      end
      incpid_pkg::ST_FF: begin
        ff  <= clamp_res;
        lim <= lim_in[DW-1] ? '0 : lim_in;
      end
      incpid_pkg::ST_CMIN: begin
        cmin <= alu_res;
      end
      incpid_pkg::ST_CMAX: begin
        cmax <= alu_res;
        if (neg_lim > cmin) begin
          cmin <= neg_lim;
        end
      end
      incpid_pkg::ST_WIN: begin
        if (lim < cmax) begin
          cmax <= lim;
        end
      end
      incpid_pkg::ST_DIFF: begin
        tmp_a <= alu_res;
      end
      incpid_pkg::ST_DBL,
      incpid_pkg::ST_MUL_P,
      incpid_pkg::ST_MUL_GI: begin
        // second difference built up in three saturating steps
        tmp_b <= alu_res;
      end
      incpid_pkg::ST_MUL_D,
      incpid_pkg::ST_ADD_I,
      incpid_pkg::ST_OUT_SUM: begin
        acc <= alu_res;
      end
      incpid_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          acc <= alu_res;
        end
      end
      incpid_pkg::ST_OUT_CLAMP: begin
        res_data <= clamp_res;
      end
      incpid_pkg::ST_FINISH: begin
        if (out_free) begin
          drive_output <= res_data;
          step_skipped <= res_skip && (op_q == incpid_pkg::OP_UPDATE);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
